@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every clock edge outside reset
`define JSU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("jsu check failed");

// next-cycle implication, checked on every clock edge outside reset
`define JSU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("jsu check failed");

`endif

@@ rtl/jsu_pkg.sv @@
`timescale 1ns / 1ps

package jsu_pkg;

    // parser mode
    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_STR  = 2'd1,
        MODE_ESC  = 2'd2,
        MODE_HEX  = 2'd3
    } t_mode;

    // result kind
    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_END  = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    // error code
    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_QUOTE = 2'd1,
        ERR_ESC   = 2'd2,
        ERR_HEX   = 2'd3
    } t_err;

    // one decoded command: up to three result bytes from one input byte
    typedef struct packed {
        logic [1:0] count_m1;
        t_kind      kind;
        t_err       err;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } t_cmd;

    localparam int JSU_QUEUE_DEPTH = 2;

    // character constants
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LO_T   = 8'h74;
    localparam logic [7:0] CH_LO_N   = 8'h6E;
    localparam logic [7:0] CH_LO_R   = 8'h72;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_LO_B   = 8'h62;
    localparam logic [7:0] CH_LO_U   = 8'h75;
    localparam logic [7:0] ASCII_MAX = 8'd127;

endpackage

@@ rtl/jsu_if.sv @@
`timescale 1ns / 1ps

// raw byte channel
interface jsu_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// decoded result channel
interface jsu_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] out_kind;
    logic [1:0] err_code;
    logic       run_last;

    modport source (output valid, output out_byte, output out_kind, output err_code,
                    output run_last, input ready);
    modport sink   (input valid, input out_byte, input out_kind, input err_code,
                    input run_last, output ready);
endinterface

@@ rtl/jsu_front.sv @@
`timescale 1ns / 1ps

module jsu_front import jsu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_space,
    output logic       o_ready,
    output logic       o_push,
    output t_cmd       o_cmd
);

    t_mode       r_mode;
    t_mode       n_mode;
    logic [1:0]  r_hex_cnt;
    logic [1:0]  n_hex_cnt;
    logic [11:0] r_hex_acc;
    logic [11:0] n_hex_acc;

    logic        fire;
    logic        is_ws;
    logic        hex_ok;
    logic [3:0]  hex_val;
    logic        esc_ok;
    logic [7:0]  esc_byte;
    logic [15:0] code_pt;
    logic        cmd_push;

    assign o_ready = i_space;
    assign fire    = i_valid & i_space;

    // byte classification
    assign is_ws = (i_byte == CH_SPACE) || (i_byte == CH_TAB) ||
                   (i_byte == CH_CR) || (i_byte == CH_LF);

    always_comb begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (i_byte inside {[8'h30:8'h39]}) begin
            hex_val = i_byte[3:0];
        end else if (i_byte inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            hex_val = i_byte[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
    end

    always_comb begin
        esc_ok   = 1'b1;
        esc_byte = i_byte;
        case (i_byte)
            CH_LO_T:   esc_byte = CH_TAB;
            CH_LO_N:   esc_byte = CH_LF;
            CH_LO_R:   esc_byte = CH_CR;
            CH_LO_F:   esc_byte = CH_FF;
            CH_LO_B:   esc_byte = CH_BS;
            CH_SLASH:  esc_byte = CH_SLASH;
            CH_BSLASH: esc_byte = CH_BSLASH;
            CH_QUOTE:  esc_byte = CH_QUOTE;
            default:   esc_ok   = 1'b0;
        endcase
    end

    assign code_pt = {r_hex_acc, hex_val};

    // next mode
    always_comb begin
        n_mode = r_mode;
        case (r_mode)
            MODE_IDLE: begin
                if (i_byte == CH_QUOTE) n_mode = MODE_STR;
            end
            MODE_STR: begin
                if (i_byte == CH_QUOTE)       n_mode = MODE_IDLE;
                else if (i_byte == CH_BSLASH) n_mode = MODE_ESC;
            end
            MODE_ESC: begin
                if (esc_ok)                  n_mode = MODE_STR;
                else if (i_byte == CH_LO_U)  n_mode = MODE_HEX;
                else                         n_mode = MODE_IDLE;
            end
            MODE_HEX: begin
                if (!hex_ok)                 n_mode = MODE_IDLE;
                else if (r_hex_cnt == 2'd3)  n_mode = MODE_STR;
            end
            default: n_mode = MODE_IDLE;
        endcase
    end

    // command and hex gathering
    always_comb begin
        cmd_push  = 1'b0;
        o_cmd     = '{count_m1: 2'd0, kind: KIND_DATA, err: ERR_NONE,
                      b0: 8'd0, b1: 8'd0, b2: 8'd0};
        n_hex_cnt = r_hex_cnt;
        n_hex_acc = r_hex_acc;
        case (r_mode)
            MODE_IDLE: begin
                if (!is_ws && (i_byte != CH_QUOTE)) begin
                    cmd_push   = 1'b1;
                    o_cmd.kind = KIND_ERR;
                    o_cmd.err  = ERR_QUOTE;
                end
            end
            MODE_STR: begin
                if (i_byte == CH_QUOTE) begin
                    cmd_push   = 1'b1;
                    o_cmd.kind = KIND_END;
                end else if (i_byte != CH_BSLASH) begin
                    cmd_push = 1'b1;
                    o_cmd.b0 = i_byte;
                end
            end
            MODE_ESC: begin
                n_hex_cnt = 2'd0;
                n_hex_acc = 12'd0;
                if (esc_ok) begin
                    cmd_push = 1'b1;
                    o_cmd.b0 = esc_byte;
                end else if (i_byte != CH_LO_U) begin
                    cmd_push   = 1'b1;
                    o_cmd.kind = KIND_ERR;
                    o_cmd.err  = ERR_ESC;
                end
            end
            MODE_HEX: begin
                if (!hex_ok) begin
                    cmd_push   = 1'b1;
                    o_cmd.kind = KIND_ERR;
                    o_cmd.err  = ERR_HEX;
                    n_hex_cnt  = 2'd0;
                    n_hex_acc  = 12'd0;
                end else if (r_hex_cnt == 2'd3) begin
                    // utf-8 encoding of the gathered code point
                    cmd_push  = 1'b1;
                    n_hex_cnt = 2'd0;
                    n_hex_acc = 12'd0;
                    if (code_pt <= 16'(ASCII_MAX)) begin
                        o_cmd.b0 = code_pt[7:0];
                    end else if (code_pt < 16'h0800) begin
                        o_cmd.count_m1 = 2'd1;
                        o_cmd.b0       = {3'b110, code_pt[10:6]};
                        o_cmd.b1       = {2'b10, code_pt[5:0]};
                    end else begin
                        o_cmd.count_m1 = 2'd2;
                        o_cmd.b0       = {4'b1110, code_pt[15:12]};
                        o_cmd.b1       = {2'b10, code_pt[11:6]};
                        o_cmd.b2       = {2'b10, code_pt[5:0]};
                    end
                end else begin
                    n_hex_cnt = r_hex_cnt + 2'd1;
                    n_hex_acc = {r_hex_acc[7:0], hex_val};
                end
            end
            default: ;
        endcase
    end

    assign o_push = fire & cmd_push;

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IDLE;
            r_hex_cnt <= 2'd0;
            r_hex_acc <= 12'd0;
        end else if (fire) begin
            r_mode    <= n_mode;
            r_hex_cnt <= n_hex_cnt;
            r_hex_acc <= n_hex_acc;
        end
    end

endmodule

@@ rtl/jsu_queue.sv @@
`timescale 1ns / 1ps

module jsu_queue import jsu_pkg::*; #(
    parameter int DEPTH = JSU_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

@@ rtl/jsu_back.sv @@
`timescale 1ns / 1ps

module jsu_back import jsu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_head_valid,
    input  t_cmd       i_head,
    output logic       o_pop,
    input  logic       i_ready,
    output logic       o_valid,
    output logic [7:0] o_byte,
    output logic [1:0] o_kind,
    output logic [1:0] o_err,
    output logic       o_last
);

    logic [1:0] r_beat;
    logic       r_valid;
    logic [7:0] r_byte;
    logic [1:0] r_kind;
    logic [1:0] r_err;
    logic       r_last;

    logic       load;
    logic       beat_last;
    logic [7:0] beat_byte;

    // output register free or draining this cycle
    assign load      = i_head_valid && (!r_valid || i_ready);
    assign beat_last = (r_beat == i_head.count_m1);
    assign o_pop     = load && beat_last;

    always_comb begin
        case (r_beat)
            2'd0:    beat_byte = i_head.b0;
            2'd1:    beat_byte = i_head.b1;
            default: beat_byte = i_head.b2;
        endcase
    end

    // beat counter and valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat  <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_beat  <= beat_last ? 2'd0 : r_beat + 2'd1;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= beat_byte;
            r_kind <= i_head.kind;
            r_err  <= i_head.err;
            r_last <= beat_last;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_kind  = r_kind;
    assign o_err   = r_err;
    assign o_last  = r_last;

endmodule

@@ rtl/json_string_unescape_utf8.sv @@
`timescale 1ns / 1ps

// channel   | dir | payload                                  | transaction
// ----------+-----+------------------------------------------+----------------------
// i_in      | in  | in_byte[7:0]                             | valid && ready
// o_res     | out | out_byte[7:0] out_kind err_code run_last | valid && ready
//
// one input byte per cycle while the result side keeps up
// a byte's first result is offered from the output register, loaded from the command queue that the transaction writes
// a \u escape giving two or three utf-8 bytes holds the result side while it emits them,
// so the command queue (QUEUE_DEPTH entries) can fill and stall the input
// i_in.ready falls only while the command queue is full
// synchronous active-low reset clears parser mode, hex state, queue and result valid

module json_string_unescape_utf8 import jsu_pkg::*; #(
    parameter int QUEUE_DEPTH = JSU_QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    jsu_byte_if.sink       i_in,
    jsu_res_if.source      o_res
);

    logic q_full;
    logic q_valid;
    logic q_push;
    logic q_pop;
    t_cmd q_cmd;
    t_cmd q_head;

    // parser front end
    jsu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_byte  (i_in.in_byte),
        .i_space (!q_full),
        .o_ready (i_in.ready),
        .o_push  (q_push),
        .o_cmd   (q_cmd)
    );

    // command queue
    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    // result back end
    jsu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_valid),
        .i_head       (q_head),
        .o_pop        (q_pop),
        .i_ready      (o_res.ready),
        .o_valid      (o_res.valid),
        .o_byte       (o_res.out_byte),
        .o_kind       (o_res.out_kind),
        .o_err        (o_res.err_code),
        .o_last       (o_res.run_last)
    );

endmodule

@@ rtl/jsu_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jsu_checker import jsu_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic [7:0] i_byte,
    input logic [1:0] i_kind,
    input logic [1:0] i_err,
    input logic       i_last
);

    // an error or end marker is always the only result of its byte
    `JSU_ASSERT_NOW(a_ctrl_last, i_valid && (i_kind != KIND_DATA), i_last)

    // end and error results carry a zero byte
    `JSU_ASSERT_NOW(a_ctrl_zero, i_valid && (i_kind != KIND_DATA), i_byte == 8'd0)

    // error code agrees with the kind
    `JSU_ASSERT_NOW(a_err_code, i_valid, (i_kind == KIND_ERR) == (i_err != ERR_NONE))

    // a non-final result is followed by a utf-8 continuation byte
    `JSU_ASSERT_NXT(a_cont, i_valid && i_ready && !i_last,
                    i_valid && (i_kind == KIND_DATA) && (i_byte[7:6] == 2'b10))

    // stalled result holds
    `JSU_ASSERT_NXT(a_hold, i_valid && !i_ready,
                    i_valid && $stable(i_byte) && $stable(i_kind) && $stable(i_last))

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_res.valid),
    .i_ready (o_res.ready),
    .i_byte  (o_res.out_byte),
    .i_kind  (o_res.out_kind),
    .i_err   (o_res.err_code),
    .i_last  (o_res.run_last)
);
